/* hdl/pool_bump_allocator_defines.svh */
// Assertion macros shared by the pool bump allocator
`ifndef POOL_BUMP_ALLOCATOR_DEFINES_SVH
`define POOL_BUMP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset
`define PBA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset
`define PBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pba_pkg.sv */
// Types and constants of the pool bump allocator
package pba_pkg;

    // Field widths
    localparam int AMOUNT_W   = 27;
    localparam int ADDR_W     = 28;
    localparam int MASK_W     = 16;
    localparam int KIND_W     = 3;
    localparam int TARGET_W   = 2;
    localparam int STATUS_W   = 2;

    // Stream and configuration port widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // Regions that have size and mode registers
    localparam int CFG_REGIONS = 4;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_START     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FREE_LOW  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FREE_HIGH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BACKUP    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESTORE   = 3'd5;

    // Allocation targets
    localparam logic [TARGET_W-1:0] TARGET_FREE = 2'd0;
    localparam logic [TARGET_W-1:0] TARGET_LOW  = 2'd1;
    localparam logic [TARGET_W-1:0] TARGET_HIGH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SMALL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_REGION = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_C = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_D = 3'd7;

    // Register reset values
    localparam logic [AMOUNT_W-1:0] SIZE_RESET = 27'd67108864;
    localparam logic [MASK_W-1:0]   MODE_RESET = 16'd4088;

    // Pool rules
    localparam logic [AMOUNT_W-1:0] MIN_REGION   = 27'd52;
    localparam logic [MASK_W-1:0]   RESERVE_MASK = 16'h0ff8;

    // Configured region sizes and modes
    typedef struct packed {
        logic [CFG_REGIONS-1:0][AMOUNT_W-1:0] size;
        logic [CFG_REGIONS-1:0][MASK_W-1:0]   mode;
    } pba_cfg_t;

    // One request item
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [AMOUNT_W-1:0] amount;
        logic [MASK_W-1:0]   need_mask;
        logic [TARGET_W-1:0] target;
        logic                clear_wanted;
    } pba_req_t;

    // One result item
    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [STATUS_W-1:0] status;
        logic                clear_block;
    } pba_res_t;

endpackage

/* hdl/pba_cfg.sv */
// Region size and mode register file
module pba_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pba_pkg::pba_cfg_t               cfg
);
    import pba_pkg::*;

    pba_cfg_t cfg_reg;

    // Register writes, sizes and modes share one data bus
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGIONS; i++)
            begin
                cfg_reg.size[i] <= SIZE_RESET;
                cfg_reg.mode[i] <= MODE_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                CFG_SIZE_A, CFG_SIZE_B, CFG_SIZE_C, CFG_SIZE_D:
                    cfg_reg.size[cfg_index[1:0]] <= cfg_data[AMOUNT_W-1:0];
                CFG_MODE_A, CFG_MODE_B, CFG_MODE_C, CFG_MODE_D:
                    cfg_reg.mode[cfg_index[1:0]] <= cfg_data[MASK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/pba_select.sv */
// Picks the largest or smallest eligible pool, ties to the higher index
module pba_select #(
    parameter int   N        = 4,
    parameter logic PICK_MAX = 1'b1
) (
    input  logic [N-1:0]                        elig,
    input  logic [N-1:0][pba_pkg::AMOUNT_W-1:0] vals,
    output logic [N-1:0]                        first_hot
);
    import pba_pkg::*;

    // All pairs compared at once; a pool wins when no eligible pool beats it
    always_comb
    begin
        logic beaten;
        for (int i = 0; i < N; i++)
        begin
            beaten = 1'b0;
            for (int j = 0; j < N; j++)
            begin
                if (j != i && elig[j])
                begin
                    if (PICK_MAX)
                        beaten = beaten | (vals[j] > vals[i]) |
                                 ((vals[j] == vals[i]) && (j > i));
                    else
                        beaten = beaten | (vals[j] < vals[i]) |
                                 ((vals[j] == vals[i]) && (j > i));
                end
            end
            first_hot[i] = elig[i] & ~beaten;
        end
    end

endmodule

/* hdl/pba_core.sv */
// Pool state and single-pass command execution
module pba_core #(
    parameter int REGION_BYTES = 67108864,
    parameter int REGION_COUNT = 4,
    parameter int HEADER_BYTES = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pba_pkg::pba_cfg_t cfg,
    input  logic              fire,
    input  pba_pkg::pba_req_t req,
    output pba_pkg::pba_res_t res
);
    import pba_pkg::*;

    localparam int N = REGION_COUNT;
    localparam logic [AMOUNT_W-1:0] SIZE_MAX = AMOUNT_W'(REGION_BYTES);
    localparam logic [AMOUNT_W-1:0] HDR      = AMOUNT_W'(HEADER_BYTES);

    // Pool state
    logic [N-1:0][ADDR_W-1:0]   pool_end_reg,   pool_end_next;
    logic [N-1:0][AMOUNT_W-1:0] pool_left_reg,  pool_left_next;
    logic [N-1:0][MASK_W-1:0]   pool_mode_reg,  pool_mode_next;
    logic [N-1:0]               pool_taken_reg, pool_taken_next;
    logic [N-1:0]               pool_present_reg, pool_present_next;
    logic [N-1:0][ADDR_W-1:0]   saved_end_reg,  saved_end_next;
    logic [N-1:0][AMOUNT_W-1:0] saved_left_reg, saved_left_next;
    logic [AMOUNT_W-1:0]        big_left_reg,   big_left_next;
    logic [ADDR_W-1:0]          big_end_reg,    big_end_next;
    logic [MASK_W-1:0]          second_mode_reg, second_mode_next;
    logic [AMOUNT_W-1:0]        second_left_reg, second_left_next;
    logic [ADDR_W-1:0]          second_end_reg,  second_end_next;

    // Pool values a start would load
    logic [N-1:0][ADDR_W-1:0]   load_end;
    logic [N-1:0][AMOUNT_W-1:0] load_left;
    logic [N-1:0][MASK_W-1:0]   load_mode;
    logic [N-1:0]               load_present;
    logic [N-1:0]               start_elig;
    logic [N-1:0]               big_hot, second_hot;

    // Allocation search
    logic [ADDR_W-1:0]          amt_sum, amt;
    logic [N-1:0]               alloc_elig, fit_hot;
    logic                       fit_any;
    logic [ADDR_W-1:0]          fit_end, fit_addr;

    // One-hot picks of start candidates
    logic [ADDR_W-1:0]          big_end_pick, second_end_pick;
    logic [AMOUNT_W-1:0]        big_left_pick, second_left_pick;
    logic [MASK_W-1:0]          second_mode_pick;

    // Per-pool start values from the region registers
    for (genvar g = 0; g < N; g++)
    begin : g_load
        localparam logic [ADDR_W-1:0] BASE = ADDR_W'(g * REGION_BYTES);
        logic [AMOUNT_W-1:0] raw, clamp, eff;

        if (g < CFG_REGIONS)
        begin : g_cfg
            assign raw          = cfg.size[g];
            assign load_mode[g] = cfg.mode[g];
        end
        else
        begin : g_absent
            assign raw          = '0;
            assign load_mode[g] = '0;
        end

        assign clamp           = (raw > SIZE_MAX) ? SIZE_MAX : raw;
        assign eff             = {clamp[AMOUNT_W-1:1], 1'b0};
        assign load_end[g]     = BASE + ADDR_W'(eff);
        assign load_left[g]    = (eff >= HDR) ? eff - HDR : '0;
        assign load_present[g] = eff >= MIN_REGION;
        assign start_elig[g]   = load_present[g] &&
                                 ((load_mode[g] & RESERVE_MASK) == RESERVE_MASK) &&
                                 (load_left[g] != '0);
    end

    // Largest reservable pool, then the largest of the rest
    pba_select #(.N(N), .PICK_MAX(1'b1)) u_big_select (
        .elig      (start_elig),
        .vals      (load_left),
        .first_hot (big_hot)
    );

    pba_select #(.N(N), .PICK_MAX(1'b1)) u_second_select (
        .elig      (start_elig & ~big_hot),
        .vals      (load_left),
        .first_hot (second_hot)
    );

    // Request size rounded up to even
    assign amt_sum = {1'b0, req.amount} + ADDR_W'(1);
    assign amt     = {amt_sum[ADDR_W-1:1], 1'b0};

    // Untagged pools that can take the request
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            alloc_elig[i] = pool_present_reg[i] && !pool_taken_reg[i] &&
                            ((pool_mode_reg[i] & req.need_mask) == req.need_mask) &&
                            ({1'b0, pool_left_reg[i]} >= amt);
        end
    end

    // Best fit is the smallest remaining space
    pba_select #(.N(N), .PICK_MAX(1'b0)) u_fit_select (
        .elig      (alloc_elig),
        .vals      (pool_left_reg),
        .first_hot (fit_hot)
    );

    // One-hot muxes
    always_comb
    begin
        fit_end          = '0;
        big_end_pick     = '0;
        big_left_pick    = '0;
        second_end_pick  = '0;
        second_left_pick = '0;
        second_mode_pick = '0;
        for (int i = 0; i < N; i++)
        begin
            fit_end          = fit_end          | (fit_hot[i]    ? pool_end_reg[i] : '0);
            big_end_pick     = big_end_pick     | (big_hot[i]    ? load_end[i]     : '0);
            big_left_pick    = big_left_pick    | (big_hot[i]    ? load_left[i]    : '0);
            second_end_pick  = second_end_pick  | (second_hot[i] ? load_end[i]     : '0);
            second_left_pick = second_left_pick | (second_hot[i] ? load_left[i]    : '0);
            second_mode_pick = second_mode_pick | (second_hot[i] ? load_mode[i]    : '0);
        end
    end

    assign fit_any  = |fit_hot;
    assign fit_addr = fit_end - amt;

    // Command execution
    always_comb
    begin
        pool_end_next     = pool_end_reg;
        pool_left_next    = pool_left_reg;
        pool_mode_next    = pool_mode_reg;
        pool_taken_next   = pool_taken_reg;
        pool_present_next = pool_present_reg;
        saved_end_next    = saved_end_reg;
        saved_left_next   = saved_left_reg;
        big_left_next     = big_left_reg;
        big_end_next      = big_end_reg;
        second_mode_next  = second_mode_reg;
        second_left_next  = second_left_reg;
        second_end_next   = second_end_reg;
        res               = '0;

        unique case (req.kind)
            KIND_START:
            begin
                pool_end_next     = load_end;
                pool_left_next    = load_left;
                pool_mode_next    = load_mode;
                pool_present_next = load_present;
                pool_taken_next   = big_hot | second_hot;
                saved_end_next    = '0;
                saved_left_next   = '0;
                big_left_next     = big_left_pick;
                big_end_next      = big_end_pick;
                second_mode_next  = second_mode_pick;
                second_left_next  = second_left_pick;
                second_end_next   = second_end_pick;
                if (!(|big_hot))
                    res.status = STATUS_NO_REGION;
            end

            KIND_ALLOC:
            begin
                if (req.target == TARGET_FREE && fit_any)
                begin
                    // best-fit untagged pool
                    for (int i = 0; i < N; i++)
                    begin
                        if (fit_hot[i])
                        begin
                            pool_end_next[i]  = fit_addr;
                            pool_left_next[i] = pool_left_reg[i] - amt[AMOUNT_W-1:0];
                        end
                    end
                    res.address     = fit_addr;
                    res.clear_block = req.clear_wanted;
                end
                else if (req.target == TARGET_FREE &&
                         ((second_mode_reg & req.need_mask) == req.need_mask) &&
                         (amt <= {1'b0, second_left_reg}))
                begin
                    // second pool
                    second_left_next = second_left_reg - amt[AMOUNT_W-1:0];
                    second_end_next  = second_end_reg - amt;
                    res.address      = second_end_reg - amt;
                    res.clear_block  = req.clear_wanted;
                end
                else if (amt > {1'b0, big_left_reg})
                begin
                    res.status = STATUS_TOO_SMALL;
                end
                else
                begin
                    // big pool, from the top or from the bottom of its free space
                    if (req.target == TARGET_HIGH)
                    begin
                        res.address = big_end_reg - {1'b0, big_left_reg};
                    end
                    else
                    begin
                        big_end_next = big_end_reg - amt;
                        res.address  = big_end_reg - amt;
                    end
                    big_left_next   = big_left_reg - amt[AMOUNT_W-1:0];
                    res.clear_block = req.clear_wanted;
                end
            end

            KIND_FREE_LOW:
            begin
                big_left_next = big_left_reg + amt[AMOUNT_W-1:0];
                big_end_next  = big_end_reg + amt;
            end

            KIND_FREE_HIGH:
            begin
                big_left_next = big_left_reg + amt[AMOUNT_W-1:0];
            end

            KIND_BACKUP:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (pool_present_reg[i] && !pool_taken_reg[i])
                    begin
                        saved_end_next[i]  = pool_end_reg[i];
                        saved_left_next[i] = pool_left_reg[i];
                    end
                end
            end

            KIND_RESTORE:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (pool_present_reg[i] && !pool_taken_reg[i])
                    begin
                        pool_end_next[i]  = saved_end_reg[i];
                        pool_left_next[i] = saved_left_reg[i];
                    end
                end
            end

            default:
            begin
                res = '0;
            end
        endcase
    end

    // Control and visible state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_taken_reg   <= '0;
            pool_present_reg <= '0;
            saved_end_reg    <= '0;
            saved_left_reg   <= '0;
            big_left_reg     <= '0;
            big_end_reg      <= '0;
            second_mode_reg  <= '0;
            second_left_reg  <= '0;
            second_end_reg   <= '0;
        end
        else if (fire)
        begin
            pool_taken_reg   <= pool_taken_next;
            pool_present_reg <= pool_present_next;
            saved_end_reg    <= saved_end_next;
            saved_left_reg   <= saved_left_next;
            big_left_reg     <= big_left_next;
            big_end_reg      <= big_end_next;
            second_mode_reg  <= second_mode_next;
            second_left_reg  <= second_left_next;
            second_end_reg   <= second_end_next;
        end
    end

    // Pool payload, only read once the pool is present
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pool_end_reg  <= pool_end_next;
            pool_left_reg <= pool_left_next;
            pool_mode_reg <= pool_mode_next;
        end
    end

endmodule

/* hdl/pool_bump_allocator.sv */
// Pool bump allocator top level: stream ports, item registers and core
//
// Requests enter on the s_axis channel: tuser carries the command kind and
// tdata the amount, need mask, target and clear flag. Each request gives
// exactly one result on the m_axis channel: granted address, status and the
// clear flag for the caller. Region sizes and modes are written through the
// cfg port (index 0..3 sizes, 4..7 modes); the user must write them only while no
// request is in flight, which the block itself does not enforce; they are sampled by a start command.
// A request accepted into the input register is executed by the core and its
// result is held in the output register, from which it is offered.
// Throughput: one request per cycle while results are taken; the start, best-fit
// and pool update logic all sits between the input register and the result register.
// Reset clears the pool state to "no pools" and the registers to 64 MiB
// regions of mode 0xff8; no clearing pass is needed.
// When the receiver stalls, the result stays in the output register and one
// more request can wait in the input register; s_axis_tready then drops.
`include "pool_bump_allocator_defines.svh"

module pool_bump_allocator #(
    parameter int REGION_BYTES = 67108864,
    parameter int REGION_COUNT = 4,
    parameter int HEADER_BYTES = 28
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // amount[26:0], need_mask[42:27], target[44:43], clear_wanted[45], zero[47:46]
    input  logic [pba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[2:0]
    input  logic [pba_pkg::KIND_W-1:0]      s_axis_tuser,
    // result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // address[27:0], status[29:28], clear_block[30], zero[31]
    output logic [pba_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import pba_pkg::*;

    pba_cfg_t cfg;
    pba_req_t in_req;
    pba_req_t in_req_reg;
    logic     in_valid_reg;
    pba_res_t core_res;
    pba_res_t out_res_reg;
    logic     out_valid_reg;
    logic     advance;

    // Configuration registers
    pba_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the request item
    always_comb
    begin
        in_req.kind         = s_axis_tuser;
        in_req.amount       = s_axis_tdata[26:0];
        in_req.need_mask    = s_axis_tdata[42:27];
        in_req.target       = s_axis_tdata[44:43];
        in_req.clear_wanted = s_axis_tdata[45];
    end

    // Execute when a request waits and the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input and output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Item payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_req_reg <= in_req;
        if (advance)
            out_res_reg <= core_res;
    end

    // Pool state and command logic
    pba_core #(
        .REGION_BYTES (REGION_BYTES),
        .REGION_COUNT (REGION_COUNT),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .req   (in_req_reg),
        .res   (core_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.clear_block, out_res_reg.status,
                            out_res_reg.address};

    // A waiting request always reaches an empty result register
    `PBA_ASSERT_NEXT(a_exec_fills_out, in_valid_reg && !out_valid_reg, out_valid_reg, "request waiting with empty output was not executed")
    // Failed commands grant nothing
    `PBA_ASSERT_SAME(a_error_no_grant, out_valid_reg && out_res_reg.status != STATUS_OK, out_res_reg.address == '0 && !out_res_reg.clear_block, "error result carries a grant")
    // Input stalls only when both item registers are full and blocked
    `PBA_ASSERT_SAME(a_stall_when_full, !s_axis_tready, in_valid_reg && out_valid_reg && !m_axis_tready, "input stalled without back-pressure")

endmodule
